// ===== src/gsa_pkg.sv =====
// Shared types, constants and helpers for the generational slot allocator.
// Used by gsa_row_calc and generational_slot_allocator_unit; depends on nothing.
package gsa_pkg;

	localparam int MAP_W     = 64;
	localparam int MAP_SH    = 6;
	localparam int IDX_OUT_W = 10;
	localparam int PADDR_W   = 3;

	localparam logic REG_ALIVE = 1'b0;
	localparam logic [31:0] ALIVE_RESET = 32'd1;

	typedef logic [MAP_SH-1:0] map_bit_t;

	typedef enum logic [2:0] {
		FN_ALLOC     = 3'd0,
		FN_RELEASE   = 3'd1,
		FN_CHECK     = 3'd2,
		FN_SET_TAGS  = 3'd3,
		FN_CLR_TAGS  = 3'd4,
		FN_SET_COMPS = 3'd5,
		FN_CLR_COMPS = 3'd6
	} func_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_FWORD,
		ST_EXEC
	} fsm_t;

	typedef struct packed {
		logic [31:0] gen;
		logic [31:0] tags;
		logic [63:0] comps;
	} row_t;

	typedef struct packed {
		logic                 succeeded;
		logic [IDX_OUT_W-1:0] index;
		logic [31:0]          generation;
		logic                 handle_valid;
		logic                 tag_match;
		logic                 comp_match;
		logic [31:0]          tags_now;
		logic [63:0]          comps_now;
	} result_t;

	typedef struct packed {
		func_t                func;
		logic                 in_range;
		logic                 full;
		logic [IDX_OUT_W-1:0] index;
		logic [31:0]          gen;
		logic [63:0]          mask;
		logic [31:0]          alive;
	} calc_req_t;

	typedef struct packed {
		row_t    row;
		logic    wr_en;
		result_t res;
	} calc_rsp_t;

	// Position of the lowest set bit of a free-map word; zero for an empty word.
	function automatic map_bit_t lowest_set(input logic [MAP_W-1:0] v);
		map_bit_t r;
		r = '0;
		for (int i = MAP_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = map_bit_t'(i);
			end
		end
		return r;
	endfunction

endpackage

// ===== src/gsa_row_calc.sv =====
// Slot row update and result formation for one request.
// Depends on gsa_pkg for the row, request and result types.
module gsa_row_calc
	import gsa_pkg::*;
(
	input  calc_req_t req,
	input  row_t      row_in,
	output calc_rsp_t rsp
);

	row_t    row_new;
	logic    valid_in;
	logic    hv;
	logic    ok;
	logic    wr;
	logic    blank;
	logic    show;
	result_t res;

	always_comb begin
		row_new  = row_in;
		wr       = 1'b0;
		ok       = 1'b0;
		blank    = 1'b0;
		valid_in = req.in_range && (req.gen != '0) && (row_in.gen == req.gen);
		hv       = valid_in;
		case (req.func)
			FN_ALLOC: begin
				row_new.gen  = row_in.gen + 32'd1;
				row_new.tags = row_in.tags | req.alive;
				wr           = !req.full;
				ok           = !req.full;
				blank        = req.full;
				hv           = row_new.gen != '0;
			end
			FN_RELEASE: begin
				if (valid_in) begin
					row_new.tags  = '0;
					row_new.comps = '0;
				end
				wr = valid_in;
				ok = valid_in;
			end
			FN_CHECK: begin
				ok = valid_in;
			end
			FN_SET_TAGS: begin
				row_new.tags = row_in.tags | req.mask[31:0];
				wr           = req.in_range;
				ok           = req.in_range;
			end
			FN_CLR_TAGS: begin
				row_new.tags = row_in.tags & ~req.mask[31:0];
				wr           = req.in_range;
				ok           = req.in_range;
			end
			FN_SET_COMPS: begin
				row_new.comps = row_in.comps | req.mask;
				wr            = req.in_range;
				ok            = req.in_range;
			end
			FN_CLR_COMPS: begin
				row_new.comps = row_in.comps & ~req.mask;
				wr            = req.in_range;
				ok            = req.in_range;
			end
			default: begin
				blank = 1'b1;
			end
		endcase

		// A full table or an unused code reports the null handle with every field zero.
		show             = req.in_range && !blank;
		res.succeeded    = ok;
		res.index        = blank ? '0 : req.index;
		res.generation   = show ? row_new.gen : '0;
		res.handle_valid = show && hv;
		res.tag_match    = show && hv && ((row_new.tags & req.mask[31:0]) != '0);
		res.comp_match   = show && ((row_new.comps & req.mask) != '0);
		res.tags_now     = show ? row_new.tags : '0;
		res.comps_now    = show ? row_new.comps : '0;

		rsp.row   = row_new;
		rsp.wr_en = wr;
		rsp.res   = res;
	end

endmodule

// ===== src/generational_slot_allocator_unit.sv =====
// Generational slot allocator top level: slot table, free map, sequencer and APB port.
// Depends on gsa_pkg and gsa_row_calc.
//
// Each slot holds a generation, a tag word and a component word in one slot memory;
// a second memory holds a free map with one bit per slot (set while the tag word is
// zero), and a register per free-map word marks words that still have a free slot.
// Requests are handled one at a time. Release, check and the tag and component
// operations do one memory read, then the update and write-back. Allocate walks
// the 4096-slot groups of the summary until one shows a free-map word with a free
// slot (a table of up to 4096 slots has one group), then reads that free-map
// word, then the chosen slot, then updates and writes back; a full table answers
// after all groups were walked. A new request is taken in the cycle after the
// previous result is registered, even while that result waits at the output.
// After reset a clearing pass zeroes the slot memory and fills the free map, one
// slot per cycle, so no request is taken until that pass ends; the alive_tag_mask
// register (offset 0) can be written at any time.
module generational_slot_allocator_unit
	import gsa_pkg::*;
#(
	parameter int SLOT_COUNT = 1024
) (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         func,
	input  logic [9:0]         slot_index,
	input  logic [31:0]        handle_generation,
	input  logic [63:0]        bit_mask,

	output logic               out_valid,
	input  logic               out_ready,
	output logic               succeeded,
	output logic [9:0]         result_index,
	output logic [31:0]        result_generation,
	output logic               handle_valid,
	output logic               tag_match,
	output logic               comp_match,
	output logic [31:0]        tags_now,
	output logic [63:0]        comps_now,

	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int IDX_W      = $clog2(SLOT_COUNT);
	localparam int FREE_WORDS = (SLOT_COUNT + MAP_W - 1) / MAP_W;
	localparam int FW_W       = (FREE_WORDS > 1) ? $clog2(FREE_WORDS) : 1;
	localparam int SUM_CHUNKS = (FREE_WORDS + MAP_W - 1) / MAP_W;
	localparam int CH_W       = (SUM_CHUNKS > 1) ? $clog2(SUM_CHUNKS) : 1;
	localparam int SUM_BITS   = SUM_CHUNKS * MAP_W;
	localparam int SB_W       = $clog2(SUM_BITS);

	typedef logic [IDX_W-1:0] slot_addr_t;
	typedef logic [FW_W-1:0]  word_addr_t;
	typedef logic [CH_W-1:0]  chunk_t;
	typedef logic [SB_W-1:0]  sum_idx_t;

	localparam slot_addr_t CLR_LAST = slot_addr_t'(SLOT_COUNT - 1);
	localparam chunk_t     CH_LAST  = chunk_t'(SUM_CHUNKS - 1);

	// Control state.
	fsm_t       state_q, state_d;
	slot_addr_t clr_q;
	chunk_t     chunk_q;
	logic       full_q;
	logic       out_valid_q;
	logic [31:0] alive_q;
	logic [SUM_BITS-1:0] summ_q;

	// Request payload.
	func_t      func_q;
	logic [9:0] idx_q;
	logic [31:0] gen_q;
	logic [63:0] mask_q;
	logic       in_range_q;
	slot_addr_t addr_q;
	word_addr_t word_q;
	result_t    res_q;

	// Memories.
	row_t             slot_mem [SLOT_COUNT];
	row_t             slot_rd_q;
	logic [MAP_W-1:0] free_mem [FREE_WORDS];
	logic [MAP_W-1:0] free_rd_q;

	logic             slot_re, slot_we;
	slot_addr_t       slot_raddr, slot_waddr;
	row_t             slot_wdata;
	logic             free_re, free_we;
	word_addr_t       free_raddr, free_waddr;
	logic [MAP_W-1:0] free_wdata;

	slot_addr_t       in_addr;
	logic             in_range;
	word_addr_t       clr_word;
	logic [MAP_W-1:0] init_word;
	logic [MAP_W-1:0] chunk_bits;
	word_addr_t       hit_word;
	slot_addr_t       alloc_addr;
	logic             take;
	logic             done;
	logic             cfg_wr;

	calc_req_t        creq;
	calc_rsp_t        crsp;

	assign in_addr    = slot_addr_t'(32'(slot_index));
	assign in_range   = 32'(slot_index) < 32'(SLOT_COUNT);
	assign clr_word   = word_addr_t'(32'(clr_q) >> MAP_SH);
	assign chunk_bits = summ_q[int'(chunk_q) * MAP_W +: MAP_W];
	assign hit_word   = word_addr_t'(int'(chunk_q) * MAP_W + int'(lowest_set(chunk_bits)));
	assign alloc_addr = slot_addr_t'(int'(word_q) * MAP_W + int'(lowest_set(free_rd_q)));

	// The last free-map word only marks slots that exist.
	always_comb begin
		for (int b = 0; b < MAP_W; b++) begin
			init_word[b] = (int'(clr_word) * MAP_W + b) < SLOT_COUNT;
		end
	end

	always_comb begin
		creq.func     = func_q;
		creq.in_range = (func_q == FN_ALLOC) ? 1'b1 : in_range_q;
		creq.full     = full_q;
		creq.index    = (func_q == FN_ALLOC) ? IDX_OUT_W'(32'(addr_q)) : idx_q;
		creq.gen      = gen_q;
		creq.mask     = mask_q;
		creq.alive    = alive_q;
	end

	gsa_row_calc u_calc (
		.req    (creq),
		.row_in (slot_rd_q),
		.rsp    (crsp)
	);

	assign take = in_valid && in_ready;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		done       = 1'b0;
		slot_re    = 1'b0;
		slot_raddr = in_addr;
		slot_we    = 1'b0;
		slot_waddr = addr_q;
		slot_wdata = crsp.row;
		free_re    = 1'b0;
		free_raddr = word_addr_t'(32'(in_addr) >> MAP_SH);
		free_we    = 1'b0;
		free_waddr = word_q;
		free_wdata = free_rd_q;
		free_wdata[map_bit_t'(32'(addr_q))] = (crsp.row.tags == '0);
		case (state_q)
			ST_CLEAR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q;
				slot_wdata = '0;
				free_we    = 1'b1;
				free_waddr = clr_word;
				free_wdata = init_word;
				if (clr_q == CLR_LAST) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					slot_re = 1'b1;
					free_re = 1'b1;
					state_d = (func_t'(func) == FN_ALLOC) ? ST_SCAN : ST_EXEC;
				end
			end
			ST_SCAN: begin
				if (chunk_bits != '0) begin
					free_re    = 1'b1;
					free_raddr = hit_word;
					state_d    = ST_FWORD;
				end else if (chunk_q == CH_LAST) begin
					state_d = ST_EXEC;
				end
			end
			ST_FWORD: begin
				slot_re    = 1'b1;
				slot_raddr = alloc_addr;
				state_d    = ST_EXEC;
			end
			ST_EXEC: begin
				// Write-back and result happen together, once the output register is free.
				if (!out_valid_q || out_ready) begin
					done    = 1'b1;
					slot_we = crsp.wr_en;
					free_we = crsp.wr_en;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			chunk_q     <= '0;
			full_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < SUM_BITS; i++) begin
				summ_q[i] <= (i < FREE_WORDS);
			end
		end else begin
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + slot_addr_t'(1);
			end
			if (take) begin
				chunk_q <= '0;
				full_q  <= 1'b0;
			end else if (state_q == ST_SCAN && chunk_bits == '0) begin
				if (chunk_q == CH_LAST) begin
					full_q <= 1'b1;
				end else begin
					chunk_q <= chunk_q + chunk_t'(1);
				end
			end
			if (done && crsp.wr_en) begin
				summ_q[sum_idx_t'(word_q)] <= (free_wdata != '0);
			end
			if (done) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			func_q     <= func_t'(func);
			idx_q      <= slot_index;
			gen_q      <= handle_generation;
			mask_q     <= bit_mask;
			in_range_q <= in_range;
			addr_q     <= in_addr;
			word_q     <= word_addr_t'(32'(in_addr) >> MAP_SH);
		end else if (state_q == ST_SCAN && chunk_bits != '0) begin
			word_q <= hit_word;
		end else if (state_q == ST_FWORD) begin
			addr_q <= alloc_addr;
		end
		if (done) begin
			res_q <= crsp.res;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		if (slot_re) begin
			slot_rd_q <= slot_mem[slot_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (free_we) begin
			free_mem[free_waddr] <= free_wdata;
		end
		if (free_re) begin
			free_rd_q <= free_mem[free_raddr];
		end
	end

	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ALIVE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= ALIVE_RESET;
		end else if (cfg_wr) begin
			alive_q <= pwdata;
		end
	end

	assign prdata = (paddr[2] == REG_ALIVE) ? alive_q : '0;
	assign pready = 1'b1;

	assign out_valid         = out_valid_q;
	assign succeeded         = res_q.succeeded;
	assign result_index      = res_q.index;
	assign result_generation = res_q.generation;
	assign handle_valid      = res_q.handle_valid;
	assign tag_match         = res_q.tag_match;
	assign comp_match        = res_q.comp_match;
	assign tags_now          = res_q.tags_now;
	assign comps_now         = res_q.comps_now;

	// The summary only points at free-map words that hold a free slot.
	a_fword_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FWORD |-> free_rd_q != '0)
		else $error("free-map word picked by the summary is empty");

	// No write-back while the finished result cannot be registered.
	a_no_write_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && out_valid_q && !out_ready) |-> (!slot_we && !free_we))
		else $error("table written while the output is stalled");

	// A new result only appears out of the execute step.
	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EXEC)
		else $error("result registered outside the execute step");

	// After a table update the sequencer is back to taking requests.
	a_idle_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		(slot_we && state_q == ST_EXEC) |=> state_q == ST_IDLE)
		else $error("sequencer did not return to idle after write-back");

endmodule
